### rtl/npcs_pkg.sv
// Package for the nearest palette color search: sizes, words, control structs, states.
package npcs_pkg;

    // Palette geometry
    localparam int PALETTE_DEPTH = 256;
    localparam int IDX_W         = $clog2(PALETTE_DEPTH);
    // entry_index addresses at most 256 slots, so the search never goes past that
    localparam int SEARCH_MAX    = (PALETTE_DEPTH < 256) ? PALETTE_DEPTH : 256;
    localparam int NUM_W         = 9;
    localparam int DIST_W        = 18;

    // Operation codes of an input word
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic        operation;
        logic [7:0]  entry_index;
        logic [23:0] entry_color;
        logic [7:0]  query_red;
        logic [7:0]  query_green;
        logic [7:0]  query_blue;
    } t_in_word;

    typedef struct packed {
        logic [7:0]        best_index;
        logic [DIST_W-1:0] best_distance;
        logic              exact_match;
    } t_out_word;

    // Controller to datapath
    typedef struct packed {
        logic wr_en;     // store the input word's color
        logic start;     // latch query, clear best, reset address
        logic issue;     // read the next palette entry
        logic load_out;  // copy best into the output register
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic last_issue;  // address register points at the last searched slot
        logic pipe_empty;  // no entry left in the compare pipeline
    } t_dp_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_DRAIN,
        S_FINISH
    } t_state;

endpackage

### rtl/npcs_datapath.sv
// Datapath: palette memory, search address counter, distance pipeline, best tracker.
module npcs_datapath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [8:0]           i_cfg_wr_data,
    input  npcs_pkg::t_in_word   i_in_word,
    input  npcs_pkg::t_dp_cmd    i_cmd,
    output npcs_pkg::t_dp_status o_status,
    output npcs_pkg::t_out_word  o_out_word
);
    import npcs_pkg::*;

    logic [23:0]       r_mem [PALETTE_DEPTH];
    logic [NUM_W-1:0]  r_num_colors;
    logic [IDX_W-1:0]  r_addr;
    logic [IDX_W-1:0]  r_last;
    logic [7:0]        r_qr, r_qg, r_qb;
    logic [23:0]       r_rd_data;
    logic              r_v1, r_v2;
    logic [IDX_W-1:0]  r_i1, r_i2;
    logic [15:0]       r_sq_r, r_sq_g, r_sq_b;
    logic              r_have_best;
    logic [IDX_W-1:0]  r_best_idx;
    logic [DIST_W-1:0] r_best_dist;
    t_out_word         r_out_word;

    logic [NUM_W-1:0]  n_count;
    logic              wr_in_range;
    logic [7:0]        dr, dg, db;
    logic [DIST_W-1:0] sum_dist;

    // Searched count: zero means one, capped at the addressable slots
    always_comb begin
        if (r_num_colors == '0) begin
            n_count = NUM_W'(1);
        end else if (r_num_colors > NUM_W'(SEARCH_MAX)) begin
            n_count = NUM_W'(SEARCH_MAX);
        end else begin
            n_count = r_num_colors;
        end
    end

    assign wr_in_range = ({24'd0, i_in_word.entry_index} < 32'(PALETTE_DEPTH));

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_colors <= NUM_W'(256);
        end else if (i_cfg_wr_en) begin
            r_num_colors <= i_cfg_wr_data;
        end
    end

    // Palette memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en && wr_in_range) begin
            r_mem[IDX_W'(i_in_word.entry_index)] <= i_in_word.entry_color;
        end
        if (i_cmd.issue) begin
            r_rd_data <= r_mem[r_addr];
        end
    end

    // Query latch and address counter
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_qr   <= i_in_word.query_red;
            r_qg   <= i_in_word.query_green;
            r_qb   <= i_in_word.query_blue;
            r_addr <= '0;
            r_last <= IDX_W'(n_count - NUM_W'(1));
        end else if (i_cmd.issue) begin
            r_addr <= r_addr + IDX_W'(1);
        end
    end

    // Pipeline valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.issue;
            r_v2 <= r_v1;
        end
    end

    // Stage 1 to 2: absolute differences and squares
    assign dr = (r_qr >= r_rd_data[23:16]) ? r_qr - r_rd_data[23:16] : r_rd_data[23:16] - r_qr;
    assign dg = (r_qg >= r_rd_data[15:8])  ? r_qg - r_rd_data[15:8]  : r_rd_data[15:8]  - r_qg;
    assign db = (r_qb >= r_rd_data[7:0])   ? r_qb - r_rd_data[7:0]   : r_rd_data[7:0]   - r_qb;

    always_ff @(posedge i_clk) begin
        if (i_cmd.issue) begin
            r_i1 <= r_addr;
        end
        r_i2   <= r_i1;
        r_sq_r <= dr * dr;
        r_sq_g <= dg * dg;
        r_sq_b <= db * db;
    end

    // Stage 3: sum and keep the first minimum
    assign sum_dist = DIST_W'(r_sq_r) + DIST_W'(r_sq_g) + DIST_W'(r_sq_b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_best <= 1'b0;
        end else if (i_cmd.start) begin
            r_have_best <= 1'b0;
        end else if (r_v2) begin
            r_have_best <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v2 && (!r_have_best || sum_dist < r_best_dist)) begin
            r_best_dist <= sum_dist;
            r_best_idx  <= r_i2;
        end
    end

    // Output word register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_word.best_index    <= 8'(r_best_idx);
            r_out_word.best_distance <= r_best_dist;
            r_out_word.exact_match   <= (r_best_dist == '0);
        end
    end

    assign o_status.last_issue = (r_addr == r_last);
    assign o_status.pipe_empty = !r_v1 && !r_v2;
    assign o_out_word          = r_out_word;

endmodule

### rtl/npcs_controller.sv
// Controller: handshakes, search sequencing and output valid.
module npcs_controller (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_operation,
    output logic                 o_in_stall,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    input  npcs_pkg::t_dp_status i_status,
    output npcs_pkg::t_dp_cmd    o_cmd
);
    import npcs_pkg::*;

    t_state  r_state, n_state;
    logic    r_out_valid, n_out_valid;
    t_dp_cmd cmd;

    // State and output valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        cmd     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_operation == OP_QUERY) begin
                        cmd.start = 1'b1;
                        n_state   = S_SEARCH;
                    end else begin
                        cmd.wr_en = 1'b1;
                    end
                end
            end
            S_SEARCH: begin
                cmd.issue = 1'b1;
                if (i_status.last_issue) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (i_status.pipe_empty) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                // wait until the output register is free or being taken
                if (!r_out_valid || !i_out_stall) begin
                    cmd.load_out = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Output valid: set on load, cleared when the word is taken
    always_comb begin
        if (cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

    // A result loads only once the compare pipeline has drained
    a_finish_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINISH) |-> i_status.pipe_empty)
        else $error("result loaded with entries still in the pipeline");

    // A waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |-> !(r_out_valid && i_out_stall))
        else $error("output word overwritten while stalled");

    // Palette writes never overlap a search
    a_write_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.wr_en |-> (i_status.pipe_empty && !cmd.issue))
        else $error("palette write during a search");

    // The search stops right after the last slot is read
    a_search_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEARCH && i_status.last_issue) |=> !cmd.issue)
        else $error("read issued past the last searched slot");

endmodule

### rtl/nearest_palette_color_search.sv
// Top level of the nearest palette color search.
//
//   channel  direction  handshake               word
//   input    in         i_in_valid / o_in_stall   t_in_word (write or query)
//   output   out        o_out_valid / i_out_stall t_out_word (one per query)
//   config   in         i_cfg_wr_en               i_cfg_wr_data (num_colors)
//
// A write word is stored as it is accepted. A query searches n entries, n being
// the searched count (1..256): the palette memory's single read port delivers
// one entry per cycle, then the compare pipeline drains and the result is loaded
// into the output register.
// Reset is synchronous, active low; palette contents are undefined until written.
// A result waits in the output register under stall while the next word is taken;
// a finished search holds until that register is free or its word is being taken.
module nearest_palette_color_search (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [8:0]          i_cfg_wr_data,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  npcs_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output npcs_pkg::t_out_word o_out_word
);
    import npcs_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    npcs_controller u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_operation (i_in_word.operation),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    npcs_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_word     (i_in_word),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_out_word    (o_out_word)
    );

endmodule
